/* design/pcma_pkg.sv */
package pcma_pkg;

  localparam int unsigned WINDOW_MAX_DEF = 8;
  localparam int unsigned COORD_BITS_DEF = 20;

  localparam int unsigned TILT_W     = 10;
  localparam int unsigned LEN_CFG_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned LANES      = 4;

  localparam logic [LEN_CFG_W-1:0] WINDOW_LEN_RST = 4'd4;
  localparam logic [TILT_W-1:0]    TILT_MIN_RST   = 10'h3C0;
  localparam logic [TILT_W-1:0]    TILT_MAX_RST   = 10'h03F;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LEN  = 3'd0,
    REG_TILT_ENABLE = 3'd1,
    REG_TILT_MIN_X  = 3'd2,
    REG_TILT_MAX_X  = 3'd3,
    REG_TILT_MIN_Y  = 3'd4,
    REG_TILT_MAX_Y  = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV_START,
    ST_DIV,
    ST_DONE
  } state_e;

  // lane order in the shared divider
  localparam int unsigned LANE_X  = 0;
  localparam int unsigned LANE_Y  = 1;
  localparam int unsigned LANE_TX = 2;
  localparam int unsigned LANE_TY = 3;

  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

endpackage

/* design/pcma_div.sv */
module pcma_div #(
  parameter int unsigned W  = 23,
  parameter int unsigned DW = 4
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pcma_pkg::div_req_t      req_i,
  input  logic [3:0][W-1:0]       dividend_i,
  input  logic [DW-1:0]           divisor_i,
  output pcma_pkg::div_rsp_t      rsp_o,
  output logic [3:0][W-1:0]       quotient_o
);
  import pcma_pkg::*;

  localparam int unsigned CNT_W = $clog2(W + 1);

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [DW-1:0]          dsr_q;
  logic [3:0][W-1:0]      quo_q, quo_d;
  logic [3:0][DW-1:0]     rem_q, rem_d;

  // restoring division, one quotient bit per lane per cycle
  always_comb begin
    logic [DW:0] trial;
    trial  = '0;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      for (int l = 0; l < int'(LANES); l++) begin
        trial = {rem_q[l], quo_q[l][W-1]};
        if (trial >= {1'b0, dsr_q}) begin
          rem_d[l] = DW'(trial - {1'b0, dsr_q});
          quo_d[l] = {quo_q[l][W-2:0], 1'b1};
        end else begin
          rem_d[l] = trial[DW-1:0];
          quo_d[l] = {quo_q[l][W-2:0], 1'b0};
        end
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (req_i.start) begin
      dsr_q <= divisor_i;
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign quotient_o = quo_q;

endmodule

/* design/pen_coordinate_moving_average_top.sv */
// Moving average of pen samples. Each accepted sample updates sliding windows of the
// last window_len positions and, with tilt on, tilts (refilled on a new stroke or the
// first sample after reset) and produces one result: truncated window means of x and y,
// and the clamped mean tilt when tilt filtering is enabled and the tool carries tilt, else
// the raw tilt. The window is summed one entry per cycle, then a shared bit-serial divider
// produces all four means on SUM_W = max(COORD_BITS, 10) + clog2(WINDOW_MAX) bits. The
// input stalls while a sample is in flight; a finished result waits in the output register.
module pen_coordinate_moving_average_top #(
  parameter int unsigned WINDOW_MAX = pcma_pkg::WINDOW_MAX_DEF,
  parameter int unsigned COORD_BITS = pcma_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pcma_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [pcma_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              new_stroke_i,
  input  logic [COORD_BITS-1:0]             pos_x_i,
  input  logic [COORD_BITS-1:0]             pos_y_i,
  input  logic signed [pcma_pkg::TILT_W-1:0] tilt_x_i,
  input  logic signed [pcma_pkg::TILT_W-1:0] tilt_y_i,
  input  logic                              tool_has_tilt_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [COORD_BITS-1:0]             avg_x_o,
  output logic [COORD_BITS-1:0]             avg_y_o,
  output logic signed [pcma_pkg::TILT_W-1:0] out_tilt_x_o,
  output logic signed [pcma_pkg::TILT_W-1:0] out_tilt_y_o
);
  import pcma_pkg::*;

  localparam int unsigned LOG_W  = $clog2(WINDOW_MAX);
  localparam int unsigned IDX_W  = (WINDOW_MAX > 1) ? LOG_W : 1;
  localparam int unsigned LEN_W  = $clog2(WINDOW_MAX + 1);
  localparam int unsigned BASE_W = (COORD_BITS > TILT_W) ? COORD_BITS : TILT_W;
  localparam int unsigned SUM_W  = BASE_W + LOG_W;
  localparam int unsigned TSUM_W = TILT_W + LOG_W;
  localparam int unsigned M_W    = TILT_W + 2;

  // configuration
  logic [LEN_CFG_W-1:0] cfg_len_q;
  logic                 cfg_ten_q;
  logic [TILT_W-1:0]    cfg_min_x_q, cfg_max_x_q, cfg_min_y_q, cfg_max_y_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q   <= WINDOW_LEN_RST;
      cfg_ten_q   <= 1'b1;
      cfg_min_x_q <= TILT_MIN_RST;
      cfg_max_x_q <= TILT_MAX_RST;
      cfg_min_y_q <= TILT_MIN_RST;
      cfg_max_y_q <= TILT_MAX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_WINDOW_LEN:  cfg_len_q   <= cfg_data_i[LEN_CFG_W-1:0];
        REG_TILT_ENABLE: cfg_ten_q   <= cfg_data_i[0];
        REG_TILT_MIN_X:  cfg_min_x_q <= cfg_data_i;
        REG_TILT_MAX_X:  cfg_max_x_q <= cfg_data_i;
        REG_TILT_MIN_Y:  cfg_min_y_q <= cfg_data_i;
        REG_TILT_MAX_Y:  cfg_max_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [LEN_W-1:0] n_len;
  always_comb begin
    if (cfg_len_q == '0) begin
      n_len = LEN_W'(1);
    end else if (32'(cfg_len_q) > WINDOW_MAX) begin
      n_len = LEN_W'(WINDOW_MAX);
    end else begin
      n_len = LEN_W'(cfg_len_q);
    end
  end

  // control
  state_e state_q, state_d;
  logic   primed_q;
  logic   out_valid_q;
  logic   tilt_on_q;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic   accept;
  logic   out_load;
  logic   tilt_on;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign tilt_on    = cfg_ten_q && tool_has_tilt_i;

  // windows
  logic [WINDOW_MAX-1:0][COORD_BITS-1:0] xw_q, yw_q;
  logic [WINDOW_MAX-1:0][TILT_W-1:0]     txw_q, tyw_q;
  logic fill;

  assign fill = new_stroke_i || !primed_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xw_q[0] <= pos_x_i;
      yw_q[0] <= pos_y_i;
      for (int i = 1; i < int'(WINDOW_MAX); i++) begin
        if (LEN_W'(i) < n_len) begin
          if (fill) begin
            xw_q[i] <= pos_x_i;
            yw_q[i] <= pos_y_i;
          end else begin
            xw_q[i] <= xw_q[i-1];
            yw_q[i] <= yw_q[i-1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      txw_q <= '0;
      tyw_q <= '0;
    end else if (accept && tilt_on) begin
      txw_q[0] <= tilt_x_i;
      tyw_q[0] <= tilt_y_i;
      for (int i = 1; i < int'(WINDOW_MAX); i++) begin
        if (LEN_W'(i) < n_len) begin
          if (fill) begin
            txw_q[i] <= tilt_x_i;
            tyw_q[i] <= tilt_y_i;
          end else begin
            txw_q[i] <= txw_q[i-1];
            tyw_q[i] <= tyw_q[i-1];
          end
        end
      end
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    div_req     = '0;
    out_load    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        idx_d = idx_q + 1'b1;
        if (LEN_W'(idx_q) == n_len - 1'b1) begin
          state_d = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        div_req.start = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (accept) begin
        primed_q <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // per-transaction data and accumulation
  logic [SUM_W-1:0]         sx_q, sy_q;
  logic signed [TSUM_W-1:0] stx_q, sty_q;
  logic [TILT_W-1:0]        tx_q, ty_q;
  logic [LEN_W-1:0]         n_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sx_q      <= '0;
      sy_q      <= '0;
      stx_q     <= '0;
      sty_q     <= '0;
      tx_q      <= tilt_x_i;
      ty_q      <= tilt_y_i;
      tilt_on_q <= tilt_on;
      n_q       <= n_len;
    end else if (state_q == ST_SUM) begin
      sx_q  <= sx_q + SUM_W'(xw_q[idx_q]);
      sy_q  <= sy_q + SUM_W'(yw_q[idx_q]);
      stx_q <= stx_q + TSUM_W'($signed(txw_q[idx_q]));
      sty_q <= sty_q + TSUM_W'($signed(tyw_q[idx_q]));
    end
  end

  logic [3:0][SUM_W-1:0] dividend, quotient;
  logic [TSUM_W-1:0]     abs_tx, abs_ty;

  assign abs_tx = stx_q[TSUM_W-1] ? TSUM_W'(-stx_q) : TSUM_W'(stx_q);
  assign abs_ty = sty_q[TSUM_W-1] ? TSUM_W'(-sty_q) : TSUM_W'(sty_q);

  always_comb begin
    dividend          = '0;
    dividend[LANE_X]  = sx_q;
    dividend[LANE_Y]  = sy_q;
    dividend[LANE_TX] = SUM_W'(abs_tx);
    dividend[LANE_TY] = SUM_W'(abs_ty);
  end

  pcma_div #(
    .W  (SUM_W),
    .DW (LEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .dividend_i (dividend),
    .divisor_i  (n_q),
    .rsp_o      (div_rsp),
    .quotient_o (quotient)
  );

  // sign restore and clamp; with crossed limits, above hi gives hi, else lo
  function automatic logic [TILT_W-1:0] clamp_tilt(
    input logic [TILT_W:0]   mag,
    input logic              neg,
    input logic [TILT_W-1:0] lo,
    input logic [TILT_W-1:0] hi
  );
    logic signed [M_W-1:0] m, lo_s, hi_s;
    logic [TILT_W-1:0]     r;
    m    = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    lo_s = M_W'($signed(lo));
    hi_s = M_W'($signed(hi));
    if (m > hi_s) begin
      r = hi;
    end else if (m < lo_s) begin
      r = lo;
    end else begin
      r = m[TILT_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      avg_x_o <= quotient[LANE_X][COORD_BITS-1:0];
      avg_y_o <= quotient[LANE_Y][COORD_BITS-1:0];
      if (tilt_on_q) begin
        out_tilt_x_o <= clamp_tilt(quotient[LANE_TX][TILT_W:0], stx_q[TSUM_W-1],
                                   cfg_min_x_q, cfg_max_x_q);
        out_tilt_y_o <= clamp_tilt(quotient[LANE_TY][TILT_W:0], sty_q[TSUM_W-1],
                                   cfg_min_y_q, cfg_max_y_q);
      end else begin
        out_tilt_x_o <= tx_q;
        out_tilt_y_o <= ty_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* design/pcma_checker.sv */
module pcma_checker #(
  parameter int unsigned COORD_BITS = pcma_pkg::COORD_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [COORD_BITS-1:0] avg_x_o,
  input logic [COORD_BITS-1:0] avg_y_o
);

  // result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(avg_x_o) && $stable(avg_y_o))
    else $error("stalled result changed or dropped");

  // busy right after a transaction is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled while sample in flight");

  // no result appears the cycle after a transaction is taken
  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

  // a new result only comes from work in flight
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a sample in flight");

endmodule

bind pen_coordinate_moving_average_top pcma_checker #(
  .COORD_BITS (COORD_BITS)
) u_pcma_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .avg_x_o     (avg_x_o),
  .avg_y_o     (avg_y_o)
);

/* sim/tb_pen_coordinate_moving_average_top.sv */
module tb_pen_coordinate_moving_average_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pcma_pkg::*;

  localparam int unsigned COORD_W         = COORD_BITS_DEF;
  localparam int unsigned WIN_MAX         = WINDOW_MAX_DEF;
  localparam int          CLK_HALF        = 5;
  localparam int          RESET_CYCLES    = 7;
  localparam int unsigned MAX_GAP         = 17;
  localparam int          N_PHASES        = 20;
  localparam int          ITEMS_PER_PHASE = 85;
  localparam int          DRAIN_CYCLES    = 64;
  localparam int          CYCLE_LIMIT     = 1000000;
  localparam int          MAX_REPORTS     = 10;
  localparam int          DIR_ROWS        = 14;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  localparam logic [COORD_W-1:0]       COORD_MAX    = '1;
  localparam logic signed [TILT_W-1:0] TILT_POS_MAX = 10'h1FF;
  localparam logic signed [TILT_W-1:0] TILT_NEG_MAX = 10'h200;

  typedef struct packed {
    logic                      new_stroke;
    logic [COORD_W-1:0]        pos_x;
    logic [COORD_W-1:0]        pos_y;
    logic signed [TILT_W-1:0]  tilt_x;
    logic signed [TILT_W-1:0]  tilt_y;
    logic                      has_tilt;
  } pen_sample_t;

  typedef struct packed {
    logic [COORD_W-1:0]        avg_x;
    logic [COORD_W-1:0]        avg_y;
    logic signed [TILT_W-1:0]  tilt_x;
    logic signed [TILT_W-1:0]  tilt_y;
  } pen_result_t;

  typedef struct packed {
    pen_sample_t s;
    logic        typed;
    pen_result_t r;
  } dir_row_t;

  localparam pen_result_t NO_RESULT = '0;

  // default config: window 4, tilt on, limits -64..63
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{'{1'b0, 20'd1000, 20'd2000, 10'h00A, 10'h3F6, 1'b1}, 1'b1,
      '{20'd1000, 20'd2000, 10'h00A, 10'h3F6}},
    '{'{1'b0, 20'd1004, 20'd2004, 10'h00E, 10'h3F2, 1'b1}, 1'b0, NO_RESULT},
    '{'{1'b1, COORD_MAX, 20'd0, TILT_POS_MAX, TILT_NEG_MAX, 1'b1}, 1'b1,
      '{COORD_MAX, 20'd0, TILT_MAX_RST, TILT_MIN_RST}},
    '{'{1'b0, COORD_MAX, 20'd0, TILT_POS_MAX, TILT_NEG_MAX, 1'b1}, 1'b1,
      '{COORD_MAX, 20'd0, TILT_MAX_RST, TILT_MIN_RST}},
    '{'{1'b0, 20'd0, COORD_MAX, TILT_NEG_MAX, TILT_POS_MAX, 1'b1}, 1'b0, NO_RESULT},
    '{'{1'b1, 20'd0, 20'd0, 10'h000, 10'h000, 1'b1}, 1'b1,
      '{20'd0, 20'd0, 10'h000, 10'h000}},
    '{'{1'b0, 20'd3, 20'd1, 10'h3FF, 10'h001, 1'b1}, 1'b0, NO_RESULT},
    '{'{1'b0, 20'd0, 20'd2, 10'h3FF, 10'h001, 1'b1}, 1'b0, NO_RESULT},
    '{'{1'b0, 20'd7, 20'd3, 10'h3FD, 10'h003, 1'b1}, 1'b0, NO_RESULT},
    '{'{1'b1, 20'd5, 20'd7, 10'h3FD, 10'h12C, 1'b0}, 1'b1,
      '{20'd5, 20'd7, 10'h3FD, 10'h12C}},
    '{'{1'b0, 20'd9, 20'd9, TILT_POS_MAX, TILT_NEG_MAX, 1'b0}, 1'b0, NO_RESULT},
    '{'{1'b0, 20'd1, 20'd1, 10'h002, 10'h002, 1'b1}, 1'b0, NO_RESULT},
    '{'{1'b1, 20'h55555, 20'hAAAAA, 10'h155, 10'h2AA, 1'b1}, 1'b1,
      '{20'h55555, 20'hAAAAA, TILT_MAX_RST, TILT_MIN_RST}},
    '{'{1'b0, 20'hAAAAA, 20'h55555, 10'h2AA, 10'h155, 1'b1}, 1'b0, NO_RESULT}
  };

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      cfg_valid_i     = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0]     cfg_data_i      = '0;
  logic                      in_valid_i      = 1'b0;
  logic                      in_stall_o;
  logic                      new_stroke_i    = 1'b0;
  logic [COORD_W-1:0]        pos_x_i         = '0;
  logic [COORD_W-1:0]        pos_y_i         = '0;
  logic signed [TILT_W-1:0]  tilt_x_i        = '0;
  logic signed [TILT_W-1:0]  tilt_y_i        = '0;
  logic                      tool_has_tilt_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_stall_i     = 1'b0;
  logic [COORD_W-1:0]        avg_x_o;
  logic [COORD_W-1:0]        avg_y_o;
  logic signed [TILT_W-1:0]  out_tilt_x_o;
  logic signed [TILT_W-1:0]  out_tilt_y_o;

  // filter model state and register copies
  logic                      primed_q = 1'b0;
  int                        filled_depth = 0;
  logic [COORD_W-1:0]        win_x  [WIN_MAX] = '{default: '0};
  logic [COORD_W-1:0]        win_y  [WIN_MAX] = '{default: '0};
  logic signed [TILT_W-1:0]  win_tx [WIN_MAX] = '{default: '0};
  logic signed [TILT_W-1:0]  win_ty [WIN_MAX] = '{default: '0};
  logic [LEN_CFG_W-1:0]      cfg_len   = WINDOW_LEN_RST;
  logic                      cfg_ten   = 1'b1;
  logic signed [TILT_W-1:0]  lim_min_x = TILT_MIN_RST;
  logic signed [TILT_W-1:0]  lim_max_x = TILT_MAX_RST;
  logic signed [TILT_W-1:0]  lim_min_y = TILT_MIN_RST;
  logic signed [TILT_W-1:0]  lim_max_y = TILT_MAX_RST;

  pen_result_t               avg_q [$];
  pen_result_t               exp_r;
  logic [COORD_W-1:0]        last_x = '0;
  logic [COORD_W-1:0]        last_y = '0;
  bit                        quiet_phase = 1'b0;
  int                        cycle_cnt = 0;
  int                        samples_sent = 0;
  int                        directed_sent = 0;
  int                        results_seen = 0;
  int                        mismatches = 0;
  int                        settings_done = 0;

  pen_coordinate_moving_average_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .new_stroke_i    (new_stroke_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .tilt_x_i        (tilt_x_i),
    .tilt_y_i        (tilt_y_i),
    .tool_has_tilt_i (tool_has_tilt_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .avg_x_o         (avg_x_o),
    .avg_y_o         (avg_y_o),
    .out_tilt_x_o    (out_tilt_x_o),
    .out_tilt_y_o    (out_tilt_y_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic int win_count();
    if (cfg_len == 0) return 1;
    if (cfg_len > WIN_MAX) return WIN_MAX;
    return int'(cfg_len);
  endfunction

  function automatic int clamp_tilt(input int m, input logic signed [TILT_W-1:0] lo,
                                    input logic signed [TILT_W-1:0] hi);
    if (m > int'(hi)) return int'(hi);
    if (m < int'(lo)) return int'(lo);
    return m;
  endfunction

  function automatic pen_result_t filter_sample(input pen_sample_t s);
    int          n;
    bit          tilt_on;
    logic [63:0] sx;
    logic [63:0] sy;
    int          stx;
    int          sty;
    pen_result_t r;
    n       = win_count();
    tilt_on = cfg_ten && s.has_tilt;
    sx = '0;
    sy = '0;
    stx = 0;
    sty = 0;
    if (s.new_stroke || !primed_q) begin
      for (int i = 0; i < n; i++) begin
        win_x[i] = s.pos_x;
        win_y[i] = s.pos_y;
        if (tilt_on) begin
          win_tx[i] = s.tilt_x;
          win_ty[i] = s.tilt_y;
        end
      end
      primed_q = 1'b1;
      if (n > filled_depth) filled_depth = n;
    end else begin
      for (int i = n - 1; i > 0; i--) begin
        win_x[i] = win_x[i-1];
        win_y[i] = win_y[i-1];
        if (tilt_on) begin
          win_tx[i] = win_tx[i-1];
          win_ty[i] = win_ty[i-1];
        end
      end
      win_x[0] = s.pos_x;
      win_y[0] = s.pos_y;
      if (tilt_on) begin
        win_tx[0] = s.tilt_x;
        win_ty[0] = s.tilt_y;
      end
    end
    for (int i = 0; i < n; i++) begin
      sx  += 64'(win_x[i]);
      sy  += 64'(win_y[i]);
      stx += int'(win_tx[i]);
      sty += int'(win_ty[i]);
    end
    r.avg_x = COORD_W'(sx / 64'(n));
    r.avg_y = COORD_W'(sy / 64'(n));
    if (tilt_on) begin
      r.tilt_x = TILT_W'(clamp_tilt(stx / n, lim_min_x, lim_max_x));
      r.tilt_y = TILT_W'(clamp_tilt(sty / n, lim_min_y, lim_max_y));
    end else begin
      r.tilt_x = s.tilt_x;
      r.tilt_y = s.tilt_y;
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if (quiet_phase) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic pen_sample_t gen_sample();
    pen_sample_t s;
    case ($urandom_range(0, 9))
      0, 1: begin
        s.pos_x = COORD_W'($urandom);
        s.pos_y = COORD_W'($urandom);
      end
      2: begin
        s.pos_x = $urandom_range(0, 1) ? COORD_MAX : '0;
        s.pos_y = $urandom_range(0, 1) ? COORD_MAX : '0;
      end
      default: begin
        // stroke-like motion around the previous point
        s.pos_x = last_x + COORD_W'($urandom_range(0, 2000)) - COORD_W'(1000);
        s.pos_y = last_y + COORD_W'($urandom_range(0, 2000)) - COORD_W'(1000);
      end
    endcase
    last_x = s.pos_x;
    last_y = s.pos_y;
    case ($urandom_range(0, 7))
      0: begin
        s.tilt_x = $urandom_range(0, 1) ? TILT_POS_MAX : TILT_NEG_MAX;
        s.tilt_y = $urandom_range(0, 1) ? TILT_POS_MAX : TILT_NEG_MAX;
      end
      1: begin
        s.tilt_x = TILT_W'(int'($urandom_range(0, 16)) - 8);
        s.tilt_y = TILT_W'(int'($urandom_range(0, 16)) - 8);
      end
      default: begin
        s.tilt_x = TILT_W'($urandom);
        s.tilt_y = TILT_W'($urandom);
      end
    endcase
    s.new_stroke = ($urandom_range(0, 15) == 0);
    s.has_tilt   = ($urandom_range(0, 4) != 0);
    // never let a grown window pull in coordinates that were never written
    if (primed_q && win_count() > filled_depth) s.new_stroke = 1'b1;
    return s;
  endfunction

  task automatic send_sample(input pen_sample_t s, input logic typed,
                             input pen_result_t typed_r);
    int unsigned gap;
    pen_result_t pred;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    new_stroke_i    <= s.new_stroke;
    pos_x_i         <= s.pos_x;
    pos_y_i         <= s.pos_y;
    tilt_x_i        <= s.tilt_x;
    tilt_y_i        <= s.tilt_y;
    tool_has_tilt_i <= s.has_tilt;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pred = filter_sample(s);
    avg_q.push_back(typed ? typed_r : pred);
    samples_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    case (idx)
      REG_WINDOW_LEN:  cfg_len   = data[LEN_CFG_W-1:0];
      REG_TILT_ENABLE: cfg_ten   = data[0];
      REG_TILT_MIN_X:  lim_min_x = data[TILT_W-1:0];
      REG_TILT_MAX_X:  lim_max_x = data[TILT_W-1:0];
      REG_TILT_MIN_Y:  lim_min_y = data[TILT_W-1:0];
      REG_TILT_MAX_Y:  lim_max_y = data[TILT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure_phase(input int p);
    logic [CFG_DATA_W-1:0] len_d;
    logic [CFG_DATA_W-1:0] en_d;
    logic [CFG_DATA_W-1:0] mnx;
    logic [CFG_DATA_W-1:0] mxx;
    logic [CFG_DATA_W-1:0] mny;
    logic [CFG_DATA_W-1:0] mxy;
    logic [CFG_DATA_W-1:0] tmp;
    len_d = CFG_DATA_W'($urandom_range(1, WIN_MAX));
    en_d  = CFG_DATA_W'($urandom_range(0, 3) != 0);
    mnx = CFG_DATA_W'($urandom);
    mxx = CFG_DATA_W'($urandom);
    mny = CFG_DATA_W'($urandom);
    mxy = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 1)) begin
      if ($signed(mnx) > $signed(mxx)) begin
        tmp = mnx; mnx = mxx; mxx = tmp;
      end
      if ($signed(mny) > $signed(mxy)) begin
        tmp = mny; mny = mxy; mxy = tmp;
      end
    end
    case (p)
      0: begin
        len_d = '0;
        en_d  = CFG_DATA_W'(1);
        mnx = TILT_NEG_MAX; mxx = TILT_POS_MAX;
        mny = TILT_NEG_MAX; mxy = TILT_POS_MAX;
      end
      1: begin
        len_d = CFG_DATA_W'(1);
        en_d  = '0;
      end
      2: begin
        // crossed limits
        len_d = CFG_DATA_W'(WIN_MAX);
        en_d  = CFG_DATA_W'(1);
        mnx = TILT_POS_MAX; mxx = TILT_NEG_MAX;
        mny = TILT_POS_MAX; mxy = TILT_NEG_MAX;
      end
      3: begin
        len_d = CFG_DATA_W'(15);
        en_d  = CFG_DATA_W'(1);
        mnx = '0; mxx = '0; mny = '0; mxy = '0;
      end
      4: begin
        len_d = CFG_DATA_W'($urandom);
        en_d  = '1;
      end
      5: begin
        len_d = CFG_DATA_W'($urandom);
        en_d  = CFG_DATA_W'($urandom);
      end
      default: begin
        if ($urandom_range(0, 7) == 0) len_d = CFG_DATA_W'($urandom);
      end
    endcase
    cfg_write(REG_WINDOW_LEN, len_d);
    cfg_write(REG_TILT_ENABLE, en_d);
    cfg_write(REG_TILT_MIN_X, mnx);
    cfg_write(REG_TILT_MAX_X, mxx);
    if (p % 3 == 1) cfg_write($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7,
                              CFG_DATA_W'($urandom));
    cfg_write(REG_TILT_MIN_Y, mny);
    cfg_write(REG_TILT_MAX_Y, mxy);
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  task automatic wait_idle();
    while (avg_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < DIR_ROWS; k++) begin
      send_sample(DIRECTED[k].s, DIRECTED[k].typed, DIRECTED[k].r);
    end
    in_valid_i <= 1'b0;
    directed_sent = samples_sent;
    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      quiet_phase = (p % 5 == 4);
      configure_phase(p);
      repeat (ITEMS_PER_PHASE) send_sample(gen_sample(), 1'b0, NO_RESULT);
      in_valid_i <= 1'b0;
    end
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("summary: %0d pen samples (%0d directed) over %0d register settings",
             samples_sent, directed_sent, settings_done);
    $display("summary: %0d results compared, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && avg_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      results_seen++;
      if (avg_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: result with no sample pending (x %0d y %0d)", avg_x_o, avg_y_o);
      end else begin
        exp_r = avg_q.pop_front();
        if (exp_r.avg_x !== avg_x_o || exp_r.avg_y !== avg_y_o ||
            exp_r.tilt_x !== out_tilt_x_o || exp_r.tilt_y !== out_tilt_y_o) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch %0d: exp x %0d y %0d tx %0d ty %0d, got x %0d y %0d tx %0d ty %0d",
                     results_seen, exp_r.avg_x, exp_r.avg_y, exp_r.tilt_x, exp_r.tilt_y,
                     avg_x_o, avg_y_o, out_tilt_x_o, out_tilt_y_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, avg_q.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule
